### src/kol_pkg.sv
`timescale 1ns / 1ps

package kol_pkg;

    localparam int DEF_POSITION_BITS    = 16;
    localparam int DEF_MAX_TOKEN_LENGTH = 1024;

    // Result queue depth; must be a power of two and at least two.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6e;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_W       = 8'h77;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_L       = 8'h6c;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_LESS    = 8'h3c;
    localparam logic [7:0] CH_GREATER = 8'h3e;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ID, ST_I, ST_IF, ST_IN, ST_INT, ST_W, ST_WH, ST_WHI, ST_WHIL,
        ST_WHILE, ST_SEMI, ST_ASSIGN, ST_LPAREN, ST_RPAREN, ST_LBRACE, ST_RBRACE,
        ST_EQ, ST_NOTEQ, ST_LT, ST_LTE, ST_GT, ST_GTE, ST_ADD, ST_SUB, ST_MUL,
        ST_DIV, ST_MOD, ST_NUM, ST_BANG
    } scan_state_t;

    typedef enum logic [4:0] {
        KIND_ID, KIND_IF, KIND_INT, KIND_WHILE, KIND_SEMI, KIND_ASSIGN,
        KIND_LPAREN, KIND_RPAREN, KIND_LBRACE, KIND_RBRACE, KIND_EQ, KIND_NOTEQ,
        KIND_LT, KIND_LTE, KIND_GT, KIND_GTE, KIND_ADD, KIND_SUB, KIND_MUL,
        KIND_DIV, KIND_MOD, KIND_NUM, KIND_ILLEGAL, KIND_BANG_ERROR
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [15:0] start;
        logic [10:0] length;
        logic        last;
    } tok_result_t;

    typedef struct packed {
        logic [1:0]  count;
        tok_result_t res_a;
        tok_result_t res_b;
    } tok_push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, [8'h09:8'h0d]};
    endfunction

    // Next state when c extends the pending token, idle when the token ends.
    function automatic scan_state_t extend(input scan_state_t st, input logic [7:0] c);
        scan_state_t nx;
        nx = ST_IDLE;
        if (st inside {[ST_ID:ST_WHILE]})
        begin
            if (is_alpha(c) || is_digit(c))
            begin
                nx = ST_ID;
                if (st == ST_I && c == CH_F)
                    nx = ST_IF;
                else if (st == ST_I && c == CH_N)
                    nx = ST_IN;
                else if (st == ST_IN && c == CH_T)
                    nx = ST_INT;
                else if (st == ST_W && c == CH_H)
                    nx = ST_WH;
                else if (st == ST_WH && c == CH_I)
                    nx = ST_WHI;
                else if (st == ST_WHI && c == CH_L)
                    nx = ST_WHIL;
                else if (st == ST_WHIL && c == CH_E)
                    nx = ST_WHILE;
            end
        end
        else if (st == ST_ASSIGN && c == CH_EQUAL)
            nx = ST_EQ;
        else if (st == ST_LT && c == CH_EQUAL)
            nx = ST_LTE;
        else if (st == ST_GT && c == CH_EQUAL)
            nx = ST_GTE;
        else if (st == ST_NUM && is_digit(c))
            nx = ST_NUM;
        return nx;
    endfunction

    // State entered from idle, idle when c starts no token.
    function automatic scan_state_t start_state(input logic [7:0] c);
        scan_state_t st;
        case (c)
            CH_I:       st = ST_I;
            CH_W:       st = ST_W;
            CH_SEMI:    st = ST_SEMI;
            CH_EQUAL:   st = ST_ASSIGN;
            CH_LPAREN:  st = ST_LPAREN;
            CH_RPAREN:  st = ST_RPAREN;
            CH_LBRACE:  st = ST_LBRACE;
            CH_RBRACE:  st = ST_RBRACE;
            CH_BANG:    st = ST_BANG;
            CH_LESS:    st = ST_LT;
            CH_GREATER: st = ST_GT;
            CH_PLUS:    st = ST_ADD;
            CH_MINUS:   st = ST_SUB;
            CH_STAR:    st = ST_MUL;
            CH_SLASH:   st = ST_DIV;
            CH_PERCENT: st = ST_MOD;
            default:
            begin
                if (is_digit(c))
                    st = ST_NUM;
                else if (is_alpha(c))
                    st = ST_ID;
                else
                    st = ST_IDLE;
            end
        endcase
        return st;
    endfunction

    function automatic token_kind_t kind_of_state(input scan_state_t st);
        token_kind_t k;
        case (st)
            ST_IF:     k = KIND_IF;
            ST_INT:    k = KIND_INT;
            ST_WHILE:  k = KIND_WHILE;
            ST_SEMI:   k = KIND_SEMI;
            ST_ASSIGN: k = KIND_ASSIGN;
            ST_LPAREN: k = KIND_LPAREN;
            ST_RPAREN: k = KIND_RPAREN;
            ST_LBRACE: k = KIND_LBRACE;
            ST_RBRACE: k = KIND_RBRACE;
            ST_EQ:     k = KIND_EQ;
            ST_NOTEQ:  k = KIND_NOTEQ;
            ST_LT:     k = KIND_LT;
            ST_LTE:    k = KIND_LTE;
            ST_GT:     k = KIND_GT;
            ST_GTE:    k = KIND_GTE;
            ST_ADD:    k = KIND_ADD;
            ST_SUB:    k = KIND_SUB;
            ST_MUL:    k = KIND_MUL;
            ST_DIV:    k = KIND_DIV;
            ST_MOD:    k = KIND_MOD;
            ST_NUM:    k = KIND_NUM;
            ST_BANG:   k = KIND_BANG_ERROR;
            default:   k = KIND_ID;
        endcase
        return k;
    endfunction

    function automatic tok_result_t make_result(input token_kind_t kind,
                                                input logic [15:0] start,
                                                input logic [10:0] length);
        tok_result_t r;
        r.kind   = kind;
        r.start  = start;
        r.length = length;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

### src/kol_core.sv
`timescale 1ns / 1ps

module kol_core #(
    parameter int POSITION_BITS    = kol_pkg::DEF_POSITION_BITS,
    parameter int MAX_TOKEN_LENGTH = kol_pkg::DEF_MAX_TOKEN_LENGTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          char_code,
    input  logic                end_of_program,
    output kol_pkg::tok_push_t  push
);
    import kol_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKEN_LENGTH);

    scan_state_t              state_reg, state_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] begin_reg, begin_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     halted_reg, halted_next;
    tok_result_t              res_a, res_b;
    logic [1:0]               n_res;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
    endfunction

    always_comb
    begin
        logic        stop;
        scan_state_t nx;
        scan_state_t ss;
        tok_result_t r;

        state_next  = state_reg;
        pos_next    = pos_reg;
        begin_next  = begin_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        res_a       = '0;
        res_b       = '0;
        n_res       = 2'd0;
        stop        = 1'b0;
        r           = '0;
        nx          = ST_IDLE;
        ss          = ST_IDLE;

        if (!halted_reg)
        begin
            // Finish or extend the pending token.
            if (state_reg == ST_BANG)
            begin
                if (char_code == CH_EQUAL)
                begin
                    state_next = ST_NOTEQ;
                    count_next = count_up(count_reg);
                end
                else
                begin
                    // A lone bang halts; the character after it is dropped.
                    res_a       = make_result(KIND_BANG_ERROR, 16'(begin_reg),
                                              11'(count_reg));
                    n_res       = 2'd1;
                    halted_next = 1'b1;
                    state_next  = ST_IDLE;
                    stop        = 1'b1;
                end
            end
            else if (state_reg != ST_IDLE)
            begin
                nx = extend(state_reg, char_code);
                if (nx != ST_IDLE)
                begin
                    state_next = nx;
                    count_next = count_up(count_reg);
                end
                else
                begin
                    res_a      = make_result(kind_of_state(state_reg), 16'(begin_reg),
                                             11'(count_reg));
                    n_res      = 2'd1;
                    state_next = ST_IDLE;
                end
            end

            if (!stop)
            begin
                // The character that ended a token is scanned again from idle.
                if (state_next == ST_IDLE)
                begin
                    ss = start_state(char_code);
                    if (ss != ST_IDLE)
                    begin
                        state_next = ss;
                        begin_next = pos_reg;
                        count_next = count_up('0);
                    end
                    else if (!is_space(char_code))
                    begin
                        r = make_result(KIND_ILLEGAL, 16'(pos_reg), 11'd1);
                        if (n_res == 2'd0)
                            res_a = r;
                        else
                            res_b = r;
                        n_res = n_res + 2'd1;
                    end
                end

                if (end_of_program)
                begin
                    if (state_next != ST_IDLE)
                    begin
                        r = make_result(kind_of_state(state_next), 16'(begin_next),
                                        11'(count_next));
                        if (n_res == 2'd0)
                            res_a = r;
                        else
                            res_b = r;
                        n_res = n_res + 2'd1;
                        if (state_next == ST_BANG)
                            halted_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                    pos_next   = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end

        res_a.last = (n_res == 2'd1);
        res_b.last = (n_res == 2'd2);

        push.count = fire ? n_res : 2'd0;
        push.res_a = res_a;
        push.res_b = res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            begin_reg  <= '0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else if (fire)
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end

endmodule

### src/kol_out_fifo.sv
`timescale 1ns / 1ps

module kol_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kol_pkg::tok_push_t   push,
    output logic                 room,
    output kol_pkg::tok_result_t head,
    output logic                 head_valid,
    input  logic                 pop
);
    import kol_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tok_result_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop_ok;

    assign head_valid  = (count_reg != '0);
    assign head        = mem[rd_ptr_reg];
    // Room for the two results one character can produce.
    assign room        = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign pop_ok      = pop && head_valid;
    assign wr_ptr_inc  = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop_ok);
    assign count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop_ok);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.res_a;
        if (push.count == 2'd2)
            mem[wr_ptr_inc] <= push.res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/keyword_operator_lexer.sv
// Timing: a character accepted into the input register is lexed once the result queue has
// room, and its first result is offered on the master side once it is written to the queue.
// Throughput: one character per cycle while the queue has room; results leave a four-entry
// queue at one per cycle while m_tready is high, so two results of a character leave in turn.
// Reset: rst_n is asynchronous and active low; it clears the scanner, position, halt flag,
// input valid flag and result queue.
`timescale 1ns / 1ps

module keyword_operator_lexer #(
    parameter int POSITION_BITS    = kol_pkg::DEF_POSITION_BITS,
    parameter int MAX_TOKEN_LENGTH = kol_pkg::DEF_MAX_TOKEN_LENGTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_program
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] token_start, [26:16] token_length, rest zero
    output logic [7:0]  m_tuser,   // [4:0] token_kind, rest zero
    output logic        m_tlast    // last_of_run
);
    import kol_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        eop_reg;
    logic        core_fire;
    logic        room;
    tok_push_t   push;
    tok_result_t head;

    assign core_fire = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || core_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (core_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
            eop_reg  <= s_tlast;
        end
    end

    kol_core #(
        .POSITION_BITS    (POSITION_BITS),
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (core_fire),
        .char_code      (char_reg),
        .end_of_program (eop_reg),
        .push           (push)
    );

    kol_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head       (head),
        .head_valid (m_tvalid),
        .pop        (m_tready)
    );

    assign m_tdata = {5'b0, head.length, head.start};
    assign m_tuser = {3'b0, head.kind};
    assign m_tlast = head.last;

endmodule

### src/kol_checker.sv
`timescale 1ns / 1ps

module kol_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [7:0]  m_tuser,
    input logic        m_tlast
);
    import kol_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result payload changed");

    // Both results of one character are queued together, so the second follows at once.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("second result of a character missing");

    a_bang_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4:0] == KIND_BANG_ERROR |-> m_tlast)
        else $error("bang error is not the final result of its character");

    a_illegal_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4:0] == KIND_ILLEGAL |-> m_tdata[26:16] == 11'd1)
        else $error("illegal character result with length other than one");

endmodule

bind keyword_operator_lexer kol_checker u_kol_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
